/* hdl/pcc_pkg.sv */
`timescale 1ns / 1ps

package pcc_pkg;

    typedef enum logic [1:0] {
        OP_RISE  = 2'd0,
        OP_FALL  = 2'd1,
        OP_CRANK = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    localparam int TIME_W = 32;
    localparam int REV_W  = 16;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd4000000;

    // figures of one channel after the current beat
    typedef struct packed {
        logic [TIME_W-1:0] edge_count;
        logic [TIME_W-1:0] last_activity;
        logic [TIME_W-1:0] low_width;
        logic [TIME_W-1:0] high_width;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] rev_on_time;
        logic [TIME_W-1:0] phase_offset;
    } chan_fig_t;

    // crank reference handed to the channels
    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] period;
    } crank_ref_t;

endpackage

/* hdl/pcc_crank.sv */
`timescale 1ns / 1ps

module pcc_crank
    import pcc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              hit,
    input  logic [TIME_W-1:0] now,
    output crank_ref_t        cur,
    output logic [TIME_W-1:0] period_next
);

    logic [TIME_W-1:0] period_reg;
    logic [TIME_W-1:0] start_reg;
    logic [TIME_W-1:0] start_next;

    always_comb begin
        period_next = period_reg;
        start_next  = start_reg;
        if (hit) begin
            period_next = now - start_reg;
            start_next  = now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= '0;
            start_reg  <= '0;
        end else begin
            period_reg <= period_next;
            start_reg  <= start_next;
        end
    end

    assign cur.start_time = start_reg;
    assign cur.period     = period_reg;

endmodule

/* hdl/pcc_channel.sv */
`timescale 1ns / 1ps

module pcc_channel
    import pcc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              hit_rise,
    input  logic              hit_fall,
    input  logic [TIME_W-1:0] now,
    input  logic [REV_W-1:0]  rev,
    input  crank_ref_t        crank,
    output chan_fig_t         fig
);

    logic [TIME_W-1:0] count_reg,    count_next;
    logic [TIME_W-1:0] activity_reg, activity_next;
    logic [TIME_W-1:0] rise_reg,     rise_next;
    logic [TIME_W-1:0] fall_reg,     fall_next;
    logic [TIME_W-1:0] low_reg,      low_next;
    logic [TIME_W-1:0] high_reg,     high_next;
    logic [TIME_W-1:0] period_reg,   period_next;
    logic [TIME_W-1:0] sum_reg,      sum_next;
    logic [TIME_W-1:0] prev_on_reg,  prev_on_next;
    logic [REV_W-1:0]  seen_rev_reg, seen_rev_next;
    logic [TIME_W-1:0] offset_reg,   offset_next;

    logic [TIME_W-1:0] width;
    logic [TIME_W-1:0] sum_add;
    logic [TIME_W-1:0] crank_diff;

    always_comb begin
        count_next    = count_reg;
        activity_next = activity_reg;
        rise_next     = rise_reg;
        fall_next     = fall_reg;
        low_next      = low_reg;
        high_next     = high_reg;
        period_next   = period_reg;
        sum_next      = sum_reg;
        prev_on_next  = prev_on_reg;
        seen_rev_next = seen_rev_reg;
        offset_next   = offset_reg;

        width      = now - rise_reg;
        sum_add    = sum_reg + width;
        crank_diff = now - crank.start_time;

        if (hit_rise) begin
            count_next    = count_reg + TIME_W'(1);
            activity_next = now;
            low_next      = now - fall_reg;
            period_next   = width;
            rise_next     = now;
        end else if (hit_fall) begin
            count_next    = count_reg + TIME_W'(1);
            activity_next = now;
            high_next     = width;
            sum_next      = sum_add;
            if (seen_rev_reg != rev) begin
                seen_rev_next = rev;
                prev_on_next  = sum_add;
                sum_next      = '0;
            end
            fall_next = now;
            if (crank_diff > (crank.period >> 1)) begin
                offset_next = crank_diff - crank.period;
            end else begin
                offset_next = crank_diff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            activity_reg <= '0;
            rise_reg     <= '0;
            fall_reg     <= '0;
            low_reg      <= '0;
            high_reg     <= '0;
            period_reg   <= '0;
            sum_reg      <= '0;
            prev_on_reg  <= '0;
            seen_rev_reg <= '0;
            offset_reg   <= '0;
        end else begin
            count_reg    <= count_next;
            activity_reg <= activity_next;
            rise_reg     <= rise_next;
            fall_reg     <= fall_next;
            low_reg      <= low_next;
            high_reg     <= high_next;
            period_reg   <= period_next;
            sum_reg      <= sum_next;
            prev_on_reg  <= prev_on_next;
            seen_rev_reg <= seen_rev_next;
            offset_reg   <= offset_next;
        end
    end

    assign fig.edge_count    = count_next;
    assign fig.last_activity = activity_next;
    assign fig.low_width     = low_next;
    assign fig.high_width    = high_next;
    assign fig.period        = period_next;
    assign fig.rev_on_time   = prev_on_next;
    assign fig.phase_offset  = offset_next;

endmodule

/* hdl/pulse_capture_with_crank_phase.sv */
`timescale 1ns / 1ps
// an input beat passes through the input register and then the result register
// throughput: one beat per cycle unless results stall; a waiting result does not stop the
// next input beat, and the input stalls only when both input and result register are held
// reset: aresetn synchronous active low; clears all channel and crank state, empties both
// registers and sets the inactivity timeout to 4000000 us

module pulse_capture_with_crank_phase
    import pcc_pkg::*;
#(
    parameter int CHANNELS = 2
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // timestamp_us[31:0], revolution[47:32]
    input  logic [47:0]  s_tdata,
    // operation[1:0], channel[2]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // event_count[31:0], low_width_us[63:32], high_width_us[95:64], period_us[127:96],
    // revolution_on_time_us[159:128], crank_offset_us[191:160], crank_period_us[223:192]
    output logic [223:0] m_tdata,
    // out_channel[0]
    output logic [0:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic              in_valid_reg;
    logic [47:0]       in_data_reg;
    logic [2:0]        in_user_reg;
    logic              out_valid_reg;
    logic [223:0]      out_data_reg;
    logic [0:0]        out_user_reg;
    logic [TIME_W-1:0] timeout_reg;

    logic              fire;
    op_t               op;
    logic              ch;
    logic [TIME_W-1:0] now;
    logic [REV_W-1:0]  rev;
    logic              ch_ok;
    logic [CH_W-1:0]   ch_idx;

    crank_ref_t        crank_cur;
    logic [TIME_W-1:0] crank_period_next;
    chan_fig_t         figs [CHANNELS];
    chan_fig_t         sel;
    logic [TIME_W-1:0] high_out;
    logic [223:0]      out_data_next;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;

    assign op     = op_t'(in_user_reg[1:0]);
    assign ch     = in_user_reg[2];
    assign now    = in_data_reg[31:0];
    assign rev    = in_data_reg[47:32];
    assign ch_ok  = (int'(ch) < CHANNELS);
    assign ch_idx = ch_ok ? CH_W'(ch) : '0;

    pcc_crank u_crank (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .hit         (fire && (op == OP_CRANK) && (ch == 1'b0)),
        .now         (now),
        .cur         (crank_cur),
        .period_next (crank_period_next)
    );

    for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
        pcc_channel u_chan (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .hit_rise (fire && (op == OP_RISE) && ch_ok && (ch_idx == CH_W'(i))),
            .hit_fall (fire && (op == OP_FALL) && ch_ok && (ch_idx == CH_W'(i))),
            .now      (now),
            .rev      (rev),
            .crank    (crank_cur),
            .fig      (figs[i])
        );
    end

    always_comb begin
        sel      = figs[ch_idx];
        high_out = sel.high_width;
        if ((now - sel.last_activity) > timeout_reg) begin
            high_out = '0;
        end
        if (ch_ok) begin
            out_data_next = {crank_period_next, sel.phase_offset, sel.rev_on_time,
                             sel.period, high_out, sel.low_width, sel.edge_count};
        end else begin
            out_data_next = {crank_period_next, 192'd0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            timeout_reg   <= TIMEOUT_RESET;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                timeout_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_user_reg <= s_tuser;
        end
        if (fire) begin
            out_data_reg <= out_data_next;
            out_user_reg <= ch;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

/* hdl/pcc_checker.sv */
`timescale 1ns / 1ps

module pcc_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [223:0] m_tdata,
    input logic [0:0]   m_tuser
);

    // input stalls only while a result is held back
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

    // accepted beat reaches the output in the cycle after the output is free
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) ##1 (!m_tvalid || m_tready) |=> m_tvalid)
        else $error("accepted beat produced no result");

    // a held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

endmodule

bind pulse_capture_with_crank_phase pcc_checker u_pcc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* verif/pulse_capture_with_crank_phase_tb.sv */
`timescale 1ns / 1ps

module pulse_capture_with_crank_phase_tb;
    import pcc_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int PRINT_CAP   = 60;

    typedef struct packed {
        logic        ch;
        logic [31:0] count;
        logic [31:0] low_w;
        logic [31:0] high_w;
        logic [31:0] period;
        logic [31:0] rev_on;
        logic [31:0] offset;
        logic [31:0] crank_per;
    } capture_figs_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [47:0]  s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [223:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [31:0]  cfg_data;

    // channel figures as the block should hold them
    logic [31:0] edges_seen  [2];
    logic [31:0] last_edge_t [2];
    logic [31:0] rise_t      [2];
    logic [31:0] fall_t      [2];
    logic [31:0] lo_w        [2];
    logic [31:0] hi_w        [2];
    logic [31:0] rise_per    [2];
    logic [31:0] sum_on      [2];
    logic [31:0] rev_on_time [2];
    logic [15:0] rev_seen    [2];
    logic [31:0] fall_offset [2];
    logic [31:0] crank_per;
    logic [31:0] crank_t;
    logic [31:0] timeout_us;

    capture_figs_t pending_figs[$];
    int            mismatches;
    int            hold_cycles;
    bit            idle_on;

    pulse_capture_with_crank_phase dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic capture_figs_t advance_capture(op_t op, logic ch, logic [31:0] ts,
                                                      logic [15:0] rev);
        capture_figs_t f;
        logic [31:0]   w;
        logic [31:0]   off;
        case (op)
            OP_RISE: begin
                edges_seen[ch]  = edges_seen[ch] + 32'd1;
                last_edge_t[ch] = ts;
                lo_w[ch]        = ts - fall_t[ch];
                rise_per[ch]    = ts - rise_t[ch];
                rise_t[ch]      = ts;
            end
            OP_FALL: begin
                edges_seen[ch]  = edges_seen[ch] + 32'd1;
                last_edge_t[ch] = ts;
                w               = ts - rise_t[ch];
                hi_w[ch]        = w;
                sum_on[ch]      = sum_on[ch] + w;
                if (rev_seen[ch] != rev) begin
                    rev_seen[ch]    = rev;
                    rev_on_time[ch] = sum_on[ch];
                    sum_on[ch]      = '0;
                end
                fall_t[ch] = ts;
                off = ts - crank_t;
                if (off > (crank_per >> 1)) off = off - crank_per;
                fall_offset[ch] = off;
            end
            OP_CRANK: begin
                if (ch == 1'b0) begin
                    crank_per = ts - crank_t;
                    crank_t   = ts;
                end
            end
            default: ;
        endcase
        f.ch        = ch;
        f.count     = edges_seen[ch];
        f.low_w     = lo_w[ch];
        f.high_w    = ((ts - last_edge_t[ch]) > timeout_us) ? '0 : hi_w[ch];
        f.period    = rise_per[ch];
        f.rev_on    = rev_on_time[ch];
        f.offset    = fall_offset[ch];
        f.crank_per = crank_per;
        return f;
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    endtask

    task automatic send_event(op_t op, logic ch, logic [31:0] ts, logic [15:0] rev);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {rev, ts};
        s_tuser  <= {ch, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_figs.push_back(advance_capture(op, ch, ts, rev));
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_figs.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_timeout(logic [31:0] value);
        settle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        timeout_us = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // result side: random stalls plus a forced hold-off when asked
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready   <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        capture_figs_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_figs.size() == 0) begin
                flag_mismatch("result beat with nothing pending", m_tdata[31:0], '0);
            end else begin
                want = pending_figs.pop_front();
                if (m_tuser[0] != want.ch)
                    flag_mismatch("out_channel", 32'(m_tuser), 32'(want.ch));
                if (m_tdata[31:0] != want.count)
                    flag_mismatch("event_count", m_tdata[31:0], want.count);
                if (m_tdata[63:32] != want.low_w)
                    flag_mismatch("low_width_us", m_tdata[63:32], want.low_w);
                if (m_tdata[95:64] != want.high_w)
                    flag_mismatch("high_width_us", m_tdata[95:64], want.high_w);
                if (m_tdata[127:96] != want.period)
                    flag_mismatch("period_us", m_tdata[127:96], want.period);
                if (m_tdata[159:128] != want.rev_on)
                    flag_mismatch("revolution_on_time_us", m_tdata[159:128], want.rev_on);
                if (m_tdata[191:160] != want.offset)
                    flag_mismatch("crank_offset_us", m_tdata[191:160], want.offset);
                if (m_tdata[223:192] != want.crank_per)
                    flag_mismatch("crank_period_us", m_tdata[223:192], want.crank_per);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic test_after_reset();
        send_event(OP_READ, 1'b0, 32'd0, 16'd0);
        send_event(OP_READ, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
        send_event(OP_READ, 1'b0, 32'hFFFF_FFFF, 16'd0);
    endtask

    task automatic test_edges_and_crank();
        // edges before any crank beat use start 0 and period 0
        send_event(OP_RISE, 1'b0, 32'd100, 16'd0);
        send_event(OP_FALL, 1'b0, 32'd250, 16'd0);
        send_event(OP_CRANK, 1'b0, 32'd1000, 16'd0);
        send_event(OP_CRANK, 1'b1, 32'd5000, 16'd0);
        send_event(OP_CRANK, 1'b0, 32'd2000, 16'd0);
        send_event(OP_RISE, 1'b0, 32'd2100, 16'd1);
        send_event(OP_FALL, 1'b0, 32'd2300, 16'd1);
        send_event(OP_RISE, 1'b0, 32'd2600, 16'd1);
        // past half a crank period, wraps negative
        send_event(OP_FALL, 1'b0, 32'd2950, 16'd1);
        send_event(OP_RISE, 1'b0, 32'd3000, 16'd2);
        send_event(OP_FALL, 1'b0, 32'd3100, 16'd2);
        send_event(OP_READ, 1'b0, 32'd3100 + TIMEOUT_RESET, 16'd2);
        send_event(OP_READ, 1'b0, 32'd3101 + TIMEOUT_RESET, 16'd2);
    endtask

    task automatic test_wrap_extremes();
        send_event(OP_RISE, 1'b1, 32'hFFFF_FFF0, 16'hFFFF);
        send_event(OP_FALL, 1'b1, 32'h0000_0010, 16'hFFFF);
        send_event(OP_CRANK, 1'b0, 32'hFFFF_FFFF, 16'h0000);
        send_event(OP_FALL, 1'b1, 32'h8000_0000, 16'h0000);
        send_event(OP_READ, 1'b1, 32'h0000_0000, 16'hFFFF);
    endtask

    task automatic test_timeout_register();
        set_timeout(32'd0);
        send_event(OP_RISE, 1'b0, 32'd5000, 16'd3);
        send_event(OP_FALL, 1'b0, 32'd5200, 16'd3);
        send_event(OP_READ, 1'b0, 32'd5200, 16'd3);
        send_event(OP_READ, 1'b0, 32'd5201, 16'd3);
        set_timeout(32'hFFFF_FFFF);
        send_event(OP_READ, 1'b0, 32'd5199, 16'd3);
        set_timeout(TIMEOUT_RESET);
    endtask

    task automatic test_backpressure();
        settle();
        idle_on     = 1'b0;
        hold_cycles = 300;
        for (int k = 0; k < 24; k++)
            send_event(op_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom,
                       16'($urandom_range(0, 65535)));
        settle();
        idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        logic [31:0] clock_us;
        logic [15:0] rev_no;
        logic        next_fall [2];
        logic [31:0] timeouts [6];
        logic        ch;
        op_t         op;
        int          pick;
        clock_us  = $urandom;
        rev_no    = 16'($urandom_range(0, 65535));
        next_fall = '{1'b0, 1'b0};
        timeouts  = '{32'd1500, 32'd0, 32'hFFFF_FFFF, 32'd40000, TIMEOUT_RESET, $urandom};
        for (int phase = 0; phase < 6; phase++) begin
            set_timeout(timeouts[phase]);
            idle_on = (phase != 2);
            for (int k = 0; k < 125; k++) begin
                if ($urandom_range(0, 99) < 80) begin
                    clock_us += ($urandom_range(0, 19) == 0) ? $urandom_range(1000000, 9000000)
                                                             : $urandom_range(0, 2500);
                    if ($urandom_range(0, 9) == 0) rev_no++;
                    pick = $urandom_range(0, 9);
                    if (pick < 7) begin
                        ch            = 1'($urandom_range(0, 1));
                        op            = next_fall[ch] ? OP_FALL : OP_RISE;
                        next_fall[ch] = !next_fall[ch];
                    end else if (pick < 9) begin
                        ch = ($urandom_range(0, 7) == 0);
                        op = OP_CRANK;
                    end else begin
                        ch = 1'($urandom_range(0, 1));
                        op = OP_READ;
                    end
                    send_event(op, ch, clock_us, rev_no);
                end else begin
                    send_event(op_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                               $urandom, 16'($urandom_range(0, 65535)));
                end
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        aclk        = 1'b0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        mismatches  = 0;
        hold_cycles = 0;
        idle_on     = 1'b1;
        for (int c = 0; c < 2; c++) begin
            edges_seen[c]  = '0;
            last_edge_t[c] = '0;
            rise_t[c]      = '0;
            fall_t[c]      = '0;
            lo_w[c]        = '0;
            hi_w[c]        = '0;
            rise_per[c]    = '0;
            sum_on[c]      = '0;
            rev_on_time[c] = '0;
            rev_seen[c]    = '0;
            fall_offset[c] = '0;
        end
        crank_per  = '0;
        crank_t    = '0;
        timeout_us = TIMEOUT_RESET;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_after_reset();
        test_edges_and_crank();
        test_wrap_extremes();
        test_timeout_register();
        test_backpressure();
        test_random_traffic();

        settle();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
